// ===== sv/acpm_pkg.sv =====
package acpm_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int ALPHABET       = 4;
    localparam int CLASS_COUNT    = 16;
    localparam int SYM_W          = 2;
    localparam int CLS_W          = 4;
    localparam int REQ_W          = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
    localparam logic [OP_W-1:0] OP_LATCH   = 4'd2;
    localparam logic [OP_W-1:0] OP_I_READ  = 4'd3;
    localparam logic [OP_W-1:0] OP_I_EVAL  = 4'd4;
    localparam logic [OP_W-1:0] OP_Q_READ  = 4'd5;
    localparam logic [OP_W-1:0] OP_Q_EVAL  = 4'd6;
    localparam logic [OP_W-1:0] OP_Q_CLASS = 4'd7;
    localparam logic [OP_W-1:0] OP_B_START = 4'd8;
    localparam logic [OP_W-1:0] OP_B_ROW   = 4'd9;
    localparam logic [OP_W-1:0] OP_B_CHILD = 4'd10;
    localparam logic [OP_W-1:0] OP_B_CHAIN = 4'd11;
    localparam logic [OP_W-1:0] OP_B_NEXT  = 4'd12;
    localparam logic [OP_W-1:0] OP_B_POP   = 4'd13;
    localparam logic [OP_W-1:0] OP_EMIT    = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic last;
        logic q_match;
        logic q_follow;
        logic b_desc;
        logic b_chain_cont;
        logic b_last_i;
        logic b_more;
        logic out_free;
        logic full;
    } stat_t;

endpackage

// ===== sv/aho_corasick_pattern_matcher.sv =====
// channel  dir  tdata (low bit up)                 tuser          tlast
// s_       in   symbol[1:0] pattern_class[5:2]     req_type[1:0]  last
// m_       out  best_class[3:0] trie_full[4]       result_kind    -
//
// Insert reads the current node, then walks to or adds the child. A query
// symbol reads the node, follows failure links until a child matches or the
// root is reached, takes the class of a match, and emits on the last symbol.
// Build walks the trie breadth-first, following failure links for each child;
// every step is one access of the single-read-port node tables. After reset a
// clearing pass zeroes the node tables; s_tready stays low during it. A full
// result register holds the controller in its emit step until m_tready.
module aho_corasick_pattern_matcher #(
    parameter int NODE_COUNT = acpm_pkg::NODE_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // symbol[1:0], pattern_class[5:2]
    input  logic [1:0] s_tuser,   // req_type[1:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // best_class[3:0], trie_full[4]
    output logic       m_tuser    // result_kind
);
    import acpm_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic             out_kind, out_full;
    logic [CLS_W-1:0] out_best;

    acpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    acpm_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_req    (s_tuser),
        .in_symbol (s_tdata[1:0]),
        .in_last   (s_tlast),
        .in_class  (s_tdata[5:2]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_best  (out_best),
        .out_full  (out_full)
    );

    assign m_tdata = {3'b000, out_full, out_best};
    assign m_tuser = out_kind;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted before table clear");
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |=> stat.full)
        else $error("trie full flag dropped");
    a_build_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[3:0] == 4'd0))
        else $error("build word carries a class");
`endif

endmodule

// ===== sv/acpm_dp.sv =====
module acpm_dp #(
    parameter int NODE_COUNT = acpm_pkg::NODE_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  acpm_pkg::cmd_t             cmd,
    output acpm_pkg::stat_t            stat,
    input  logic [acpm_pkg::REQ_W-1:0] in_req,
    input  logic [acpm_pkg::SYM_W-1:0] in_symbol,
    input  logic                       in_last,
    input  logic [acpm_pkg::CLS_W-1:0] in_class,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       out_kind,
    output logic [acpm_pkg::CLS_W-1:0] out_best,
    output logic                       out_full
);
    import acpm_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int ROW_W = ALPHABET * NW;
    localparam logic [NW-1:0]    ROOT      = NW'(1);
    localparam logic [NW-1:0]    NODE_LIM  = NW'(NODE_COUNT - 1);
    localparam logic [CLS_W-1:0] CLASS_MAX = CLS_W'(CLASS_COUNT - 1);

    logic [ROW_W-1:0] child_mem [NODE_COUNT];
    logic [NW-1:0]    fail_mem  [NODE_COUNT];
    logic [CLS_W-1:0] class_mem [NODE_COUNT];
    logic [NW-1:0]    queue_mem [NODE_COUNT];

    logic [ROW_W-1:0] rd_row;
    logic [NW-1:0]    rd_fail;
    logic [CLS_W-1:0] rd_class;
    logic [NW-1:0]    rd_queue;

    logic [NW-1:0]    raddr, qraddr;
    logic             cw_en, fw_en, kw_en, qw_en;
    logic [NW-1:0]    cw_addr, fw_addr, kw_addr;
    logic [ROW_W-1:0] cw_data;
    logic [NW-1:0]    fw_data;
    logic [CLS_W-1:0] kw_data;

    logic [NW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;
    logic [CLS_W-1:0] cls_reg, cls_next;
    logic [NW-1:0]    ins_cur_reg, ins_cur_next;
    logic [NW-1:0]    q_cur_reg, q_cur_next;
    logic [CLS_W-1:0] q_best_reg, q_best_next;
    logic             full_reg, full_next;
    logic [NW-1:0]    nodes_reg, nodes_next;
    logic [NW-1:0]    head_reg, head_next;
    logic [NW-1:0]    tail_reg, tail_next;
    logic [ROW_W-1:0] urow_reg, urow_next;
    logic [NW-1:0]    ufail_reg, ufail_next;
    logic [SYM_W-1:0] idx_reg, idx_next;
    logic [NW-1:0]    c_reg, c_next;
    logic             ov_reg, ov_next;
    logic             okind_reg, okind_next;
    logic [CLS_W-1:0] obest_reg, obest_next;
    logic             ofull_reg, ofull_next;

    logic [NW-1:0] q_child, u_child, r_child;

    assign q_child = rd_row[sym_reg*NW +: NW];
    assign u_child = urow_reg[idx_reg*NW +: NW];
    assign r_child = rd_row[idx_reg*NW +: NW];

    always_comb begin
        logic [NW-1:0]    cur;
        logic [ROW_W-1:0] new_row;
        cur          = ins_cur_reg;
        new_row      = rd_row;
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        cls_next     = cls_reg;
        ins_cur_next = ins_cur_reg;
        q_cur_next   = q_cur_reg;
        q_best_next  = q_best_reg;
        full_next    = full_reg;
        nodes_next   = nodes_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        urow_next    = urow_reg;
        ufail_next   = ufail_reg;
        idx_next     = idx_reg;
        c_next       = c_reg;
        ov_next      = ov_reg & ~out_ready;
        okind_next   = okind_reg;
        obest_next   = obest_reg;
        ofull_next   = ofull_reg;
        raddr        = q_cur_reg;
        qraddr       = head_reg;
        cw_en = 1'b0; cw_addr = clr_cnt_reg; cw_data = '0;
        fw_en = 1'b0; fw_addr = clr_cnt_reg; fw_data = '0;
        kw_en = 1'b0; kw_addr = clr_cnt_reg; kw_data = '0;
        qw_en = 1'b0;
        case (cmd.op)
            OP_CLEAR: begin
                cw_en = 1'b1;
                fw_en = 1'b1;
                kw_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + NW'(1);
            end
            OP_LATCH: begin
                req_next  = in_req;
                sym_next  = in_symbol;
                last_next = in_last;
                cls_next  = (in_class > CLASS_MAX) ? CLASS_MAX : in_class;
            end
            OP_I_READ: raddr = ins_cur_reg;
            OP_I_EVAL: begin
                if (ins_cur_reg != '0) begin
                    if (q_child != '0) begin
                        cur = q_child;
                    end else if (nodes_reg < NODE_LIM) begin
                        cur        = nodes_reg + NW'(1);
                        nodes_next = cur;
                        new_row[sym_reg*NW +: NW] = cur;
                        cw_en   = 1'b1;
                        cw_addr = ins_cur_reg;
                        cw_data = new_row;
                    end else begin
                        full_next = 1'b1;
                        cur       = '0;
                    end
                end
                if (last_reg) begin
                    if (cur != '0) begin
                        kw_en   = 1'b1;
                        kw_addr = cur;
                        kw_data = cls_reg;
                    end
                    ins_cur_next = ROOT;
                end else begin
                    ins_cur_next = cur;
                end
            end
            OP_Q_READ: raddr = q_cur_reg;
            OP_Q_EVAL: begin
                if (q_child != '0) begin
                    q_cur_next = q_child;
                    raddr      = q_child;
                end else if (rd_fail != '0) begin
                    q_cur_next = rd_fail;
                    raddr      = rd_fail;
                end
            end
            OP_Q_CLASS: begin
                if (rd_class > q_best_reg) q_best_next = rd_class;
            end
            OP_B_START: begin
                raddr     = ROOT;
                head_next = '0;
                tail_next = '0;
            end
            OP_B_ROW: begin
                urow_next  = rd_row;
                ufail_next = rd_fail;
                idx_next   = '0;
            end
            OP_B_CHILD: begin
                c_next = u_child;
                if (u_child != '0 && ufail_reg != '0) begin
                    raddr = ufail_reg;
                end else begin
                    if (u_child != '0) begin
                        fw_en     = 1'b1;
                        fw_addr   = u_child;
                        fw_data   = ROOT;
                        qw_en     = 1'b1;
                        tail_next = tail_reg + NW'(1);
                    end
                    idx_next = idx_reg + SYM_W'(1);
                end
            end
            OP_B_CHAIN: begin
                if (r_child == '0 && rd_fail != '0) begin
                    raddr = rd_fail;
                end else begin
                    fw_en     = 1'b1;
                    fw_addr   = c_reg;
                    fw_data   = (r_child != '0) ? r_child : ROOT;
                    qw_en     = 1'b1;
                    tail_next = tail_reg + NW'(1);
                    idx_next  = idx_reg + SYM_W'(1);
                end
            end
            OP_B_NEXT: begin
                if (head_reg != tail_reg) head_next = head_reg + NW'(1);
            end
            OP_B_POP: raddr = rd_queue;
            OP_EMIT: begin
                ov_next    = 1'b1;
                okind_next = (req_reg == REQ_BUILD);
                obest_next = (req_reg == REQ_BUILD) ? '0 : q_best_reg;
                ofull_next = full_reg;
                if (req_reg != REQ_BUILD) begin
                    q_cur_next  = ROOT;
                    q_best_next = '0;
                end
            end
            default: ;
        endcase
    end

    // enqueue data is the child node in both build steps
    always_ff @(posedge aclk) begin
        if (cw_en) child_mem[cw_addr] <= cw_data;
        rd_row <= child_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (fw_en) fail_mem[fw_addr] <= fw_data;
        rd_fail <= fail_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (kw_en) class_mem[kw_addr] <= kw_data;
        rd_class <= class_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (qw_en) queue_mem[tail_reg] <= (cmd.op == OP_B_CHILD) ? u_child : c_reg;
        rd_queue <= queue_mem[qraddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            ins_cur_reg <= ROOT;
            q_cur_reg   <= ROOT;
            q_best_reg  <= '0;
            full_reg    <= 1'b0;
            nodes_reg   <= ROOT;
            ov_reg      <= 1'b0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            ins_cur_reg <= ins_cur_next;
            q_cur_reg   <= q_cur_next;
            q_best_reg  <= q_best_next;
            full_reg    <= full_next;
            nodes_reg   <= nodes_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        cls_reg   <= cls_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        urow_reg  <= urow_next;
        ufail_reg <= ufail_next;
        idx_reg   <= idx_next;
        c_reg     <= c_next;
        okind_reg <= okind_next;
        obest_reg <= obest_next;
        ofull_reg <= ofull_next;
    end

    assign stat.clr_done     = (clr_cnt_reg == NODE_LIM);
    assign stat.last         = last_reg;
    assign stat.q_match      = (q_child != '0);
    assign stat.q_follow     = (q_child == '0) && (rd_fail != '0);
    assign stat.b_desc       = (u_child != '0) && (ufail_reg != '0);
    assign stat.b_chain_cont = (r_child == '0) && (rd_fail != '0);
    assign stat.b_last_i     = (idx_reg == SYM_W'(ALPHABET - 1));
    assign stat.b_more       = (head_reg != tail_reg);
    assign stat.out_free     = ~ov_reg | out_ready;
    assign stat.full         = full_reg;

    assign out_valid = ov_reg;
    assign out_kind  = okind_reg;
    assign out_best  = obest_reg;
    assign out_full  = ofull_reg;

endmodule

// ===== sv/acpm_ctrl.sv =====
module acpm_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [acpm_pkg::REQ_W-1:0] in_req,
    output logic                       in_ready,
    input  acpm_pkg::stat_t            stat,
    output acpm_pkg::cmd_t             cmd
);
    import acpm_pkg::*;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_I_READ  = 4'd2;
    localparam logic [3:0] S_I_EVAL  = 4'd3;
    localparam logic [3:0] S_Q_READ  = 4'd4;
    localparam logic [3:0] S_Q_EVAL  = 4'd5;
    localparam logic [3:0] S_Q_CLASS = 4'd6;
    localparam logic [3:0] S_B_START = 4'd7;
    localparam logic [3:0] S_B_ROW   = 4'd8;
    localparam logic [3:0] S_B_CHILD = 4'd9;
    localparam logic [3:0] S_B_CHAIN = 4'd10;
    localparam logic [3:0] S_B_NEXT  = 4'd11;
    localparam logic [3:0] S_B_POP   = 4'd12;
    localparam logic [3:0] S_EMIT    = 4'd13;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLR: begin
                cmd.op = OP_CLEAR;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op = OP_LATCH;
                    case (in_req)
                        REQ_INSERT: state_next = S_I_READ;
                        REQ_BUILD:  state_next = S_B_START;
                        REQ_QUERY:  state_next = S_Q_READ;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_I_READ: begin
                cmd.op     = OP_I_READ;
                state_next = S_I_EVAL;
            end
            S_I_EVAL: begin
                cmd.op     = OP_I_EVAL;
                state_next = S_IDLE;
            end
            S_Q_READ: begin
                cmd.op     = OP_Q_READ;
                state_next = S_Q_EVAL;
            end
            S_Q_EVAL: begin
                cmd.op = OP_Q_EVAL;
                if (stat.q_match)       state_next = S_Q_CLASS;
                else if (stat.q_follow) state_next = S_Q_EVAL;
                else if (stat.last)     state_next = S_EMIT;
                else                    state_next = S_IDLE;
            end
            S_Q_CLASS: begin
                cmd.op     = OP_Q_CLASS;
                state_next = stat.last ? S_EMIT : S_IDLE;
            end
            S_B_START: begin
                cmd.op     = OP_B_START;
                state_next = S_B_ROW;
            end
            S_B_ROW: begin
                cmd.op     = OP_B_ROW;
                state_next = S_B_CHILD;
            end
            S_B_CHILD: begin
                cmd.op = OP_B_CHILD;
                if (stat.b_desc)        state_next = S_B_CHAIN;
                else if (stat.b_last_i) state_next = S_B_NEXT;
            end
            S_B_CHAIN: begin
                cmd.op = OP_B_CHAIN;
                if (!stat.b_chain_cont) state_next = stat.b_last_i ? S_B_NEXT : S_B_CHILD;
            end
            S_B_NEXT: begin
                cmd.op     = OP_B_NEXT;
                state_next = stat.b_more ? S_B_POP : S_EMIT;
            end
            S_B_POP: begin
                cmd.op     = OP_B_POP;
                state_next = S_B_ROW;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== verif/aho_corasick_pattern_matcher_tb.sv =====
`timescale 1ns / 100ps

module aho_corasick_pattern_matcher_tb;
    import acpm_pkg::*;

    localparam int NODES = NODE_COUNT_DEF;
    localparam int ROOT  = 1;

    typedef struct packed {
        logic       kind;
        logic [3:0] best;
        logic       full;
    } answer_t;

    typedef struct {
        logic [1:0] req;
        logic [1:0] sym;
        logic       lst;
        logic [3:0] cls;
        logic       typed;   // expected answer given in the row
        answer_t    ans;
    } row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;

    aho_corasick_pattern_matcher dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // trie mirror
    int unsigned kids [NODES*ALPHABET];
    int unsigned fails [NODES];
    int unsigned classes [NODES];
    int unsigned used, ins_at, qry_at, qry_best;
    bit          full_seen;

    answer_t answers_due [$];
    int      errors = 0;
    bit      hold_off = 1'b0;
    bit      stim_done = 1'b0;

    function automatic int unsigned kid(int unsigned n, int unsigned s);
        return (n < NODES) ? kids[n*ALPHABET + s] : 0;
    endfunction

    function automatic int unsigned fl(int unsigned n);
        return (n < NODES) ? fails[n] : 0;
    endfunction

    function automatic void mirror_reset();
        foreach (kids[i]) kids[i] = 0;
        foreach (fails[i]) begin
            fails[i] = 0;
            classes[i] = 0;
        end
        used = 1;
        ins_at = ROOT;
        qry_at = ROOT;
        qry_best = 0;
        full_seen = 0;
    endfunction

    function automatic void build_links();
        int unsigned order [$];
        int unsigned u, c, f, g;
        fails[ROOT] = 0;
        for (int s = 0; s < ALPHABET; s++) begin
            c = kid(ROOT, s);
            if (c != 0) begin
                fails[c] = ROOT;
                order.push_back(c);
            end
        end
        while (order.size() > 0) begin
            u = order.pop_front();
            for (int s = 0; s < ALPHABET; s++) begin
                c = kid(u, s);
                if (c == 0) continue;
                f = fl(u);
                g = 0;
                while (f != 0 && kid(f, s) == 0 && g < NODES) begin
                    f = fl(f);
                    g++;
                end
                fails[c] = (f != 0 && kid(f, s) != 0) ? kid(f, s) : ROOT;
                order.push_back(c);
            end
        end
    endfunction

    // advance the mirror by one word; returns 1 if an answer is due
    function automatic bit match_step(logic [1:0] req, logic [1:0] sym, logic lst,
                                      logic [3:0] cls, output answer_t a);
        int unsigned nx, now, g;
        a = '0;
        case (req)
            REQ_INSERT: begin
                if (ins_at != 0 && ins_at < NODES) begin
                    nx = kid(ins_at, sym);
                    if (nx == 0) begin
                        if (used < NODES - 1) begin
                            used++;
                            nx = used;
                            kids[ins_at*ALPHABET + sym] = nx;
                        end else begin
                            full_seen = 1;
                        end
                    end
                    ins_at = nx;
                end
                if (lst) begin
                    if (ins_at != 0 && ins_at < NODES) classes[ins_at] = cls;
                    ins_at = ROOT;
                end
                return 0;
            end
            REQ_BUILD: begin
                build_links();
                a = '{kind: 1'b1, best: 4'd0, full: full_seen};
                return 1;
            end
            REQ_QUERY: begin
                now = qry_at;
                g = 0;
                while (kid(now, sym) == 0 && fl(now) != 0 && g < NODES) begin
                    now = fl(now);
                    g++;
                end
                nx = kid(now, sym);
                if (nx != 0) begin
                    now = nx;
                    if (classes[now] > qry_best) qry_best = classes[now];
                end
                qry_at = now;
                if (!lst) return 0;
                a = '{kind: 1'b0, best: qry_best[3:0], full: full_seen};
                qry_at = ROOT;
                qry_best = 0;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_word(logic [1:0] req, logic [1:0] sym, logic lst, logic [3:0] cls);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, cls, sym};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drive_row(row_t r);
        answer_t a;
        bit due;
        due = match_step(r.req, r.sym, r.lst, r.cls, a);
        if (due) begin
            if (r.typed && a != r.ans) begin
                errors++;
                if (errors <= 10)
                    $display("table row answer %h disagrees with predictor %h", r.ans, a);
            end
            answers_due.push_back(a);
        end
        send_word(r.req, r.sym, r.lst, r.cls);
    endtask

    task automatic send_item(logic [1:0] req, logic [1:0] sym, logic lst, logic [3:0] cls);
        row_t r;
        r = '{req: req, sym: sym, lst: lst, cls: cls, typed: 1'b0, ans: '0};
        drive_row(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (answers_due.size() > 0);
    endtask

    task automatic random_pattern();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_item(REQ_INSERT, $urandom_range(0, 3), i == n - 1, $urandom_range(0, 15));
    endtask

    task automatic random_query();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_item(REQ_QUERY, $urandom_range(0, 3), i == n - 1, $urandom_range(0, 15));
    endtask

    row_t steps [$];

    initial begin
        int pick;
        mirror_reset();
        // directed table
        steps = '{
            '{REQ_BUILD,  2'd0, 1'b0, 4'd0,  1'b1, '{1'b1, 4'd0, 1'b0}},
            '{REQ_QUERY,  2'd3, 1'b1, 4'd15, 1'b1, '{1'b0, 4'd0, 1'b0}},
            '{REQ_INSERT, 2'd0, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_INSERT, 2'd1, 1'b1, 4'd15, 1'b0, '0},
            '{REQ_INSERT, 2'd1, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_INSERT, 2'd2, 1'b1, 4'd7,  1'b0, '0},
            '{REQ_INSERT, 2'd3, 1'b1, 4'd1,  1'b0, '0},
            '{2'd3,       2'd3, 1'b1, 4'd15, 1'b0, '0},
            // query before build: mismatch leaves cursor
            '{REQ_QUERY,  2'd0, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd0, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd1, 1'b1, 4'd0,  1'b0, '0},
            '{REQ_BUILD,  2'd0, 1'b0, 4'd0,  1'b1, '{1'b1, 4'd0, 1'b0}},
            '{REQ_QUERY,  2'd0, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd1, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd2, 1'b1, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd3, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd0, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd1, 1'b1, 4'd0,  1'b0, '0},
            '{2'd3,       2'd0, 1'b0, 4'd0,  1'b0, '0},
            '{REQ_QUERY,  2'd2, 1'b1, 4'd8,  1'b0, '0}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (steps[i]) drive_row(steps[i]);
        drain();

        // random: a mix of patterns, builds, queries and stray words, mostly queries
        for (int k = 0; k < 200; ) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                random_pattern();
                k += 3;
            end else if (pick < 42) begin
                send_item(REQ_BUILD, $urandom_range(0, 3), $urandom_range(0, 1),
                          $urandom_range(0, 15));
                k++;
            end else if (pick < 92) begin
                random_query();
                k += 4;
            end else begin
                send_item($urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 1), $urandom_range(0, 15));
                k++;
            end
            if (k > 150 && k < 160) begin
                // receiver releases this itself after its stretch
                hold_off = 1'b1;
                for (int j = 0; j < 12; j++) random_query();
                k += 10;
            end
            if (k > 100 && k < 106) begin
                drain();
                k += 6;
            end
        end

        // fill the trie to force the full flag
        for (int p = 0; p < 40 && !full_seen; p++) begin
            for (int i = 0; i < 16; i++)
                send_item(REQ_INSERT, $urandom_range(0, 3), i == 15, $urandom_range(0, 15));
        end
        for (int i = 0; i < 3; i++) random_pattern();
        send_item(REQ_BUILD, 2'd0, 1'b0, 4'd0);
        for (int i = 0; i < 10; i++) random_query();

        drain();
        repeat (200) @(posedge aclk);
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off
    initial begin
        int wait_n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // result check
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, best: m_tdata[3:0], full: m_tdata[4]};
            if (answers_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word kind=%0d best=%0d full=%0d",
                                           got.kind, got.best, got.full);
            end else begin
                want = answers_due.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("word mismatch: exp kind=%0d best=%0d full=%0d, got %0d %0d %0d",
                                 want.kind, want.best, want.full,
                                 got.kind, got.best, got.full);
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        if (errors == 0 && answers_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
